[hdl/rbsh_pkg.sv]
// Shared types and constants for the ray-box slab test.
package rbsh_pkg;

  localparam int unsigned CoordFracBits    = 16;
  localparam int unsigned CellSubdivisions = 16;

  localparam int unsigned OrgW = 32;
  localparam int unsigned DirW = 18;
  localparam int unsigned BoxW = 9;
  localparam int unsigned RotW = 2;
  localparam int unsigned FaceW = 3;
  localparam int unsigned TimeW = 32;
  // Extended time width: two extra bits so unbounded values sit outside the saturated range.
  localparam int unsigned TExtW = TimeW + 2;

  localparam logic [FaceW-1:0] FaceTop    = 3'd0;
  localparam logic [FaceW-1:0] FaceBottom = 3'd1;
  localparam logic [FaceW-1:0] FaceRight  = 3'd2;
  localparam logic [FaceW-1:0] FaceBack   = 3'd3;
  localparam logic [FaceW-1:0] FaceLeft   = 3'd4;
  localparam logic [FaceW-1:0] FaceFront  = 3'd5;

  localparam logic [RotW-1:0] RotNone = 2'd0;
  localparam logic [RotW-1:0] Rot90   = 2'd1;
  localparam logic [RotW-1:0] Rot180  = 2'd2;
  localparam logic [RotW-1:0] Rot270  = 2'd3;

  // One axis of a slab job handed from the front part to the back part.
  typedef struct packed {
    logic signed [OrgW+1:0] num_first;   // first plane minus origin
    logic signed [OrgW+1:0] num_second;  // second plane minus origin
    logic signed [DirW-1:0] dir;
    logic                   zero_dir;
    logic                   in_slab;     // origin within slab (zero direction only)
  } rbsh_axis_t;

  typedef struct packed {
    rbsh_axis_t ax;
    rbsh_axis_t ay;
    rbsh_axis_t az;
  } rbsh_job_t;

  typedef struct packed {
    logic hit;
    logic [FaceW-1:0] face;
  } rbsh_res_t;

endpackage

[hdl/rbsh_front.sv]
// Front part: box rotation, plane positions and slab numerators for all three axes.
module rbsh_front #(
  parameter int unsigned COORD_FRAC_BITS   = rbsh_pkg::CoordFracBits,
  parameter int unsigned CELL_SUBDIVISIONS = rbsh_pkg::CellSubdivisions
) (
  input  logic signed [rbsh_pkg::OrgW-1:0] org_x_i,
  input  logic signed [rbsh_pkg::OrgW-1:0] org_y_i,
  input  logic signed [rbsh_pkg::OrgW-1:0] org_z_i,
  input  logic signed [rbsh_pkg::DirW-1:0] dir_x_i,
  input  logic signed [rbsh_pkg::DirW-1:0] dir_y_i,
  input  logic signed [rbsh_pkg::DirW-1:0] dir_z_i,
  input  logic [rbsh_pkg::BoxW-1:0]        box_x_i,
  input  logic [rbsh_pkg::BoxW-1:0]        box_y_i,
  input  logic [rbsh_pkg::BoxW-1:0]        box_z_i,
  input  logic [rbsh_pkg::RotW-1:0]        rotation_i,
  output rbsh_pkg::rbsh_job_t              job_o
);
  import rbsh_pkg::*;

  localparam int unsigned KW = 9;   // signed sixteenth count: -30..46 fits
  localparam int unsigned PW = OrgW + 2;
  localparam int signed NS = CELL_SUBDIVISIONS;

  logic signed [KW-1:0] offx, sizx, offy, sizy, offz, sizz;
  logic signed [KW-1:0] axo, axs, azo, azs;

  // Plane at k subdivisions, floor(k * 2^F / N).
  function automatic logic signed [PW-1:0] plane_of(input logic signed [KW-1:0] k);
    logic signed [63:0] p;
    logic signed [63:0] q;
    begin
      p = 64'(k) <<< COORD_FRAC_BITS;
      q = p / NS;
      if ((p % NS) != 0 && p < 0) q = q - 1;
      plane_of = PW'(q);
    end
  endfunction

  function automatic rbsh_axis_t mk_axis(input logic signed [PW-1:0] pf,
                                         input logic signed [PW-1:0] ps,
                                         input logic signed [OrgW-1:0] org,
                                         input logic signed [DirW-1:0] d);
    rbsh_axis_t a;
    logic signed [PW-1:0] o, lo, hi;
    begin
      o = PW'(org);
      lo = (pf < ps) ? pf : ps;
      hi = (pf < ps) ? ps : pf;
      a.num_first  = pf - o;
      a.num_second = ps - o;
      a.dir        = d;
      a.zero_dir   = (d == '0);
      a.in_slab    = !(o < lo || o > hi);
      mk_axis = a;
    end
  endfunction

  always_comb begin
    offx = KW'(box_x_i[3:0]); sizx = KW'(box_x_i[8:4]);
    offy = KW'(box_y_i[3:0]); sizy = KW'(box_y_i[8:4]);
    offz = KW'(box_z_i[3:0]); sizz = KW'(box_z_i[8:4]);
    axo = offx; axs = sizx; azo = offz; azs = sizz;
    unique case (rotation_i)
      Rot90: begin
        axs = sizz; azs = sizx; axo = KW'(NS) - sizz - offz; azo = offx;
      end
      Rot180: begin
        axo = KW'(NS) - sizx - offx; azo = KW'(NS) - sizz - offz;
      end
      Rot270: begin
        axs = sizz; azs = sizx; axo = offz; azo = KW'(NS) - sizx - offx;
      end
      default: ;
    endcase
    job_o.ax = mk_axis(plane_of(axo + axs), plane_of(axo), org_x_i, dir_x_i);
    job_o.ay = mk_axis(plane_of(offy + sizy), plane_of(offy), org_y_i, dir_y_i);
    job_o.az = mk_axis(plane_of(azo), plane_of(azo + azs), org_z_i, dir_z_i);
  end

endmodule

[hdl/rbsh_fifo.sv]
// Short queue between the front and back parts.
module rbsh_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_ready_o  = (cnt_q != (AW+1)'(DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push) wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (pop)  rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    cnt_d = cnt_q + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(DEPTH)) else $error("queue count overflow");
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("push lost");
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1) else $error("pop lost");
`endif

endmodule

[hdl/rbsh_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with stall.
module rbsh_div #(
  parameter int unsigned COORD_FRAC_BITS = rbsh_pkg::CoordFracBits,
  parameter int unsigned TAGW = 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic signed [rbsh_pkg::OrgW+1:0] num_i,
  input  logic signed [rbsh_pkg::DirW-1:0] den_i,
  input  logic [TAGW-1:0] tag_i,
  output logic valid_o,
  output logic signed [rbsh_pkg::TExtW-1:0] time_o,
  output logic [TAGW-1:0] tag_o
);
  import rbsh_pkg::*;

  // Dividend magnitude: |num| << F needs up to OrgW+2+F bits.
  localparam int unsigned NW = OrgW + 2 + COORD_FRAC_BITS;
  localparam int unsigned DW = DirW;
  localparam int unsigned ST = NW;  // one quotient bit per stage

  logic [NW-1:0]   quo_q [ST+1];
  logic [DW:0]     rem_q [ST+1];
  logic [DW-1:0]   dv_q  [ST+1];
  logic            neg_q [ST+1];
  logic            vld_q [ST+1];
  logic [TAGW-1:0] tag_q [ST+1];
  logic signed [NW:0] q_s;

  always_comb begin
    logic [NW-1:0] mag_n;
    logic [DW-1:0] mag_d;
    logic signed [NW:0] nx;
    nx = (NW+1)'(num_i) <<< COORD_FRAC_BITS;
    mag_n = nx[NW] ? NW'(-nx) : nx[NW-1:0];
    mag_d = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
    quo_q[0] = mag_n;
    rem_q[0] = '0;
    dv_q[0]  = mag_d;
    neg_q[0] = nx[NW] ^ den_i[DW-1];
    vld_q[0] = valid_i;
    tag_q[0] = tag_i;
  end

  for (genvar s = 0; s < ST; s++) begin : g_st
    logic [DW+1:0] trial;
    logic [DW:0] sh;
    assign sh = {rem_q[s][DW-1:0], quo_q[s][NW-1]};
    assign trial = {1'b0, sh} - {2'b00, dv_q[s]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[s+1] <= 1'b0;
      else if (en_i) vld_q[s+1] <= vld_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= trial[DW+1] ? sh : trial[DW:0];
        quo_q[s+1] <= {quo_q[s][NW-2:0], ~trial[DW+1]};
        dv_q[s+1]  <= dv_q[s];
        neg_q[s+1] <= neg_q[s];
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  // Apply sign, then saturate to the signed 32-bit range.
  always_comb begin
    q_s = neg_q[ST] ? -(NW+1)'(quo_q[ST]) : (NW+1)'(quo_q[ST]);
    if (q_s > (NW+1)'(64'sd2147483647)) time_o = TExtW'(64'sd2147483647);
    else if (q_s < -(NW+1)'(64'sd2147483648)) time_o = TExtW'(-64'sd2147483648);
    else time_o = TExtW'(q_s);
  end
  assign valid_o = vld_q[ST];
  assign tag_o   = tag_q[ST];

endmodule

[hdl/rbsh_back.sv]
// Back part: six slab divisions, per-axis ordering, face choice and output register.
module rbsh_back #(
  parameter int unsigned COORD_FRAC_BITS = rbsh_pkg::CoordFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  rbsh_pkg::rbsh_job_t job_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output rbsh_pkg::rbsh_res_t res_o
);
  import rbsh_pkg::*;

  localparam int unsigned TagW = 9;  // per axis: zero_dir, in_slab, plus padding
  localparam logic signed [TExtW-1:0] TUnb = TExtW'(64'sd1 << 32);

  logic en;
  logic [5:0] dvld;
  logic signed [TExtW-1:0] t [6];
  logic [TagW-1:0] tg [6];
  logic [TagW-1:0] tag_in;
  rbsh_axis_t axs [3];
  logic out_vld_q;
  rbsh_res_t out_q, res_d;

  // Pipeline advances whenever the output register is free or being drained.
  assign en = !out_vld_q || res_ready_i;
  assign job_ready_o = en;
  assign axs[0] = job_i.ax;
  assign axs[1] = job_i.ay;
  assign axs[2] = job_i.az;
  assign tag_in = {3'b000, job_i.az.zero_dir, job_i.az.in_slab, job_i.ay.zero_dir,
                   job_i.ay.in_slab, job_i.ax.zero_dir, job_i.ax.in_slab};

  for (genvar i = 0; i < 6; i++) begin : g_div
    rbsh_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .TAGW(TagW)) u_div (
      .clk_i, .rst_ni, .en_i(en), .valid_i(job_valid_i),
      .num_i((i % 2 == 0) ? axs[i/2].num_first : axs[i/2].num_second),
      .den_i(axs[i/2].zero_dir ? DirW'(1) : axs[i/2].dir),
      .tag_i(tag_in), .valid_o(dvld[i]), .time_o(t[i]), .tag_o(tg[i]));
  end

  always_comb begin
    logic signed [TExtW-1:0] tin [3];
    logic signed [TExtW-1:0] tout [3];
    logic [FaceW-1:0] f [3];
    logic ok, zd, ins;
    logic signed [TExtW-1:0] tmin, tmax;
    logic [FaceW-1:0] face;
    logic [FaceW-1:0] ff [3];
    logic [FaceW-1:0] fs [3];
    ff[0] = FaceRight; fs[0] = FaceLeft;
    ff[1] = FaceTop;   fs[1] = FaceBottom;
    ff[2] = FaceFront; fs[2] = FaceBack;
    ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      zd  = tg[0][2*a+1];
      ins = tg[0][2*a];
      if (zd) begin
        if (!ins) ok = 1'b0;
        tin[a] = -TUnb; tout[a] = TUnb; f[a] = fs[a];
      end else if (t[2*a] < t[2*a+1]) begin
        tin[a] = t[2*a]; tout[a] = t[2*a+1]; f[a] = ff[a];
      end else begin
        tin[a] = t[2*a+1]; tout[a] = t[2*a]; f[a] = fs[a];
      end
    end
    if (tin[0] > tin[1]) begin face = f[0]; tmin = tin[0]; end
    else begin face = f[1]; tmin = tin[1]; end
    if (tin[2] > tmin) begin face = f[2]; tmin = tin[2]; end
    tmax = (tout[0] < tout[1]) ? tout[0] : tout[1];
    if (tout[2] < tmax) tmax = tout[2];
    res_d.hit = ok && !(tmax < 0 || tmin > tmax);
    res_d.face = res_d.hit ? face : FaceTop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= dvld[0];
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= res_d;
  end
  assign res_valid_o = out_vld_q;
  assign res_o = out_q;

`ifndef SYNTHESIS
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvld[0] == dvld[5] && dvld[1] == dvld[3]) else $error("divider lanes out of step");
  a_miss_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.hit) |-> out_q.face == FaceTop) else $error("face on miss");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_ready_i) |=> out_vld_q && $stable(out_q)) else $error("result lost");
`endif

endmodule

[hdl/ray_box_slab_hit_face.sv]
// Top level of the ray against sub-box slab test.
//
//  channel | dir | fields (tdata low bit first)
//  s_axis  | in  | rel_origin_x/y/z, dir_x/y/z, box_x/y/z, rotation
//  m_axis  | out | hit, entry_face
//
// One word is accepted per cycle while the two-entry queue has room. Its result
// word is offered once it has passed in turn through the queue entry, written at
// the accepting edge, the 50 divider stages (one quotient bit each for the 50-bit
// dividend) and the output register. The back pipeline stalls as a whole while
// the output register holds an untaken word, and the queue then fills. Reset
// clears all valid flags; no payload is reset.
module ray_box_slab_hit_face #(
  parameter int unsigned COORD_FRAC_BITS   = rbsh_pkg::CoordFracBits,
  parameter int unsigned CELL_SUBDIVISIONS = rbsh_pkg::CellSubdivisions
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // rel_origin_x[31:0], rel_origin_y[63:32], rel_origin_z[95:64],
  // dir_x[113:96], dir_y[131:114], dir_z[149:132], box_x[158:150],
  // box_y[167:159], box_z[176:168], rotation[178:177], zero fill to 184
  input  logic [183:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit[0], entry_face[3:1], zero fill to 8
  output logic [7:0]   m_axis_tdata
);
  import rbsh_pkg::*;

  rbsh_job_t job, q_job;
  logic q_valid, q_ready;
  rbsh_res_t res;

  // Classification of the incoming word into per-axis slab jobs.
  rbsh_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .CELL_SUBDIVISIONS(CELL_SUBDIVISIONS))
    u_front (
      .org_x_i(s_axis_tdata[31:0]),   .org_y_i(s_axis_tdata[63:32]),
      .org_z_i(s_axis_tdata[95:64]),  .dir_x_i(s_axis_tdata[113:96]),
      .dir_y_i(s_axis_tdata[131:114]), .dir_z_i(s_axis_tdata[149:132]),
      .box_x_i(s_axis_tdata[158:150]), .box_y_i(s_axis_tdata[167:159]),
      .box_z_i(s_axis_tdata[176:168]), .rotation_i(s_axis_tdata[178:177]),
      .job_o(job));

  // The queue lets the input side keep taking words while the back part stalls.
  rbsh_fifo #(.WIDTH($bits(rbsh_job_t)), .DEPTH(2)) u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_data_i(job),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_job));

  rbsh_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(q_valid), .job_ready_o(q_ready), .job_i(q_job),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res));

  assign m_axis_tdata = {4'b0000, res.face, res.hit};

endmodule

[tb/tb_ray_box_slab_hit_face.sv]
// Testbench for the ray against sub-box slab test: random and directed rays checked by a predictor.
`timescale 1ns / 100ps

module tb_ray_box_slab_hit_face;
  import rbsh_pkg::*;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned DrainCycles = 100;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [183:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [7:0]   m_axis_tdata;

  // Expected results, oldest first, as {entry_face, hit}.
  logic [3:0] hit_face_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned idle_cycles = 0;

  ray_box_slab_hit_face u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Plane at k sub-cell steps, rounded towards minus infinity.
  function automatic longint plane_at(longint k);
    longint p;
    longint q;
    p = k * (longint'(1) << CoordFracBits);
    q = p / longint'(CellSubdivisions);
    if ((p % longint'(CellSubdivisions)) != 0 && p < 0) q = q - 1;
    return q;
  endfunction

  // Crossing time of one plane, truncated towards zero and saturated to 32 bits.
  function automatic longint cross_time(longint num, longint d);
    longint q;
    q = (num * (longint'(1) << CoordFracBits)) / d;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  // One axis of the slab test; returns 0 when a zero direction leaves the origin outside.
  function automatic bit axis_span(longint pf, longint ps, longint o, longint d,
                                   logic [FaceW-1:0] ff, logic [FaceW-1:0] fs,
                                   output longint tin, output longint tout,
                                   output logic [FaceW-1:0] f);
    longint lo;
    longint hi;
    longint tf;
    longint ts;
    if (d == 0) begin
      lo = (pf < ps) ? pf : ps;
      hi = (pf < ps) ? ps : pf;
      tin = -(longint'(1) << 40);
      tout = longint'(1) << 40;
      f = fs;
      return !(o < lo || o > hi);
    end
    tf = cross_time(pf - o, d);
    ts = cross_time(ps - o, d);
    if (tf < ts) begin
      f = ff; tin = tf; tout = ts;
    end else begin
      f = fs; tin = ts; tout = tf;
    end
    return 1'b1;
  endfunction

  // Expected {entry_face, hit} for one input word.
  function automatic logic [3:0] predict_hit_face(logic [183:0] w);
    longint org[3];
    longint dir[3];
    longint off[3];
    longint siz[3];
    longint ax_off, ax_siz, az_off, az_siz, n;
    longint tin[3];
    longint tout[3];
    longint tmin, tmax;
    logic [FaceW-1:0] f[3];
    logic [FaceW-1:0] face;
    logic [RotW-1:0] rot;
    bit ok;
    for (int i = 0; i < 3; i++) begin
      org[i] = longint'($signed(w[32*i +: 32]));
      dir[i] = longint'($signed(w[96 + 18*i +: 18]));
      off[i] = longint'(w[150 + 9*i +: 4]);
      siz[i] = longint'(w[154 + 9*i +: 5]);
    end
    rot = w[177 +: 2];
    n = longint'(CellSubdivisions);
    ax_off = off[0]; ax_siz = siz[0]; az_off = off[2]; az_siz = siz[2];
    case (rot)
      Rot90: begin
        ax_siz = siz[2]; az_siz = siz[0];
        ax_off = n - siz[2] - off[2]; az_off = off[0];
      end
      Rot180: begin
        ax_off = n - siz[0] - off[0]; az_off = n - siz[2] - off[2];
      end
      Rot270: begin
        ax_siz = siz[2]; az_siz = siz[0];
        ax_off = off[2]; az_off = n - siz[0] - off[0];
      end
      default: ;
    endcase
    ok = axis_span(plane_at(ax_off + ax_siz), plane_at(ax_off), org[0], dir[0],
                   FaceRight, FaceLeft, tin[0], tout[0], f[0]);
    ok = axis_span(plane_at(off[1] + siz[1]), plane_at(off[1]), org[1], dir[1],
                   FaceTop, FaceBottom, tin[1], tout[1], f[1]) && ok;
    ok = axis_span(plane_at(az_off), plane_at(az_off + az_siz), org[2], dir[2],
                   FaceFront, FaceBack, tin[2], tout[2], f[2]) && ok;
    if (!ok) return {FaceTop, 1'b0};
    if (tin[0] > tin[1]) begin
      face = f[0]; tmin = tin[0];
    end else begin
      face = f[1]; tmin = tin[1];
    end
    if (tin[2] > tmin) begin
      face = f[2]; tmin = tin[2];
    end
    tmax = (tout[0] < tout[1]) ? tout[0] : tout[1];
    if (tout[2] < tmax) tmax = tout[2];
    if (tmax < 0 || tmin > tmax) return {FaceTop, 1'b0};
    return {face, 1'b1};
  endfunction

  function automatic logic [183:0] pack_ray(int ox, int oy, int oz,
                                            int dx, int dy, int dz,
                                            logic [8:0] bx, logic [8:0] by,
                                            logic [8:0] bz, logic [RotW-1:0] rot);
    logic [183:0] w;
    w = '0;
    w[31:0] = ox;
    w[63:32] = oy;
    w[95:64] = oz;
    w[113:96] = dx[17:0];
    w[131:114] = dy[17:0];
    w[149:132] = dz[17:0];
    w[158:150] = bx;
    w[167:159] = by;
    w[176:168] = bz;
    w[178:177] = rot;
    return w;
  endfunction

  // Origin near the voxel, often exactly on a sub-cell plane so that ties occur.
  function automatic int near_origin();
    if ($urandom_range(3) == 0) return ($urandom_range(48) - 16) * 4096;
    return $urandom_range(4 * 65536) - 2 * 65536;
  endfunction

  function automatic int unit_dir();
    case ($urandom_range(7))
      0: return 0;
      1: return ($urandom_range(1) != 0) ? 65536 : -65536;
      default: return $urandom_range(2 * 65536) - 65536;
    endcase
  endfunction

  // Sends one word; the sender may sit idle for a few cycles first.
  task automatic send_ray(logic [183:0] w);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (receiver_stall_pct != 0) begin
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Predicts on every accepted input word and checks every accepted result word.
  always @(posedge clk_i) begin
    logic [3:0] exp_hf;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      hit_face_q.push_back(predict_hit_face(s_axis_tdata));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (hit_face_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("Unexpected result word %h", m_axis_tdata);
      end else begin
        exp_hf = hit_face_q.pop_front();
        if (m_axis_tdata[0] !== exp_hf[0] || m_axis_tdata[3:1] !== exp_hf[3:1]) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("Mismatch: hit %0b face %0d expected, hit %0b face %0d seen",
                     exp_hf[0], exp_hf[3:1], m_axis_tdata[0], m_axis_tdata[3:1]);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves a word.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic random_rays(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8) begin
        send_ray(pack_ray(near_origin(), near_origin(), near_origin(),
                          unit_dir(), unit_dir(), unit_dir(),
                          9'($urandom), 9'($urandom), 9'($urandom), 2'($urandom)));
      end else begin
        // Raw noise over every bit of every field.
        send_ray(pack_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          9'($urandom), 9'($urandom), 9'($urandom), 2'($urandom)));
      end
    end
  endtask

  task automatic test_directed();
    logic [8:0] full_box;
    full_box = 9'h100;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    // Axis-aligned rays into each face of the full voxel.
    send_ray(pack_ray(32768, 131072, 32768, 0, -65536, 0, full_box, full_box, full_box, RotNone));
    send_ray(pack_ray(32768, -65536, 32768, 0, 65536, 0, full_box, full_box, full_box, RotNone));
    send_ray(pack_ray(131072, 32768, 32768, -65536, 0, 0, full_box, full_box, full_box, RotNone));
    send_ray(pack_ray(-65536, 32768, 32768, 65536, 0, 0, full_box, full_box, full_box, RotNone));
    send_ray(pack_ray(32768, 32768, -65536, 0, 0, 65536, full_box, full_box, full_box, RotNone));
    send_ray(pack_ray(32768, 32768, 131072, 0, 0, -65536, full_box, full_box, full_box, RotNone));
    // Zero direction with the origin outside a slab misses.
    send_ray(pack_ray(200000, 32768, 32768, 0, 0, 65536, full_box, full_box, full_box, RotNone));
    // Origin exactly on a slab bound with zero direction counts as inside.
    send_ray(pack_ray(65536, 0, 32768, 0, 0, 65536, full_box, full_box, full_box, RotNone));
    // All-zero direction: unbounded entry resolves to the bottom face.
    send_ray(pack_ray(32768, 32768, 32768, 0, 0, 0, full_box, full_box, full_box, RotNone));
    // Diagonal through a corner gives equal entry times on all axes.
    send_ray(pack_ray(-65536, -65536, -65536, 46341, 46341, 46341,
                      full_box, full_box, full_box, RotNone));
    send_ray(pack_ray(-65536, -65536, -65536, 65536, 65536, 65536,
                      full_box, full_box, full_box, RotNone));
    // Each rotation of an off-centre box.
    for (int r = 0; r < 4; r++) begin
      send_ray(pack_ray(-65536, 20000, 30000, 65536, 1000, 2000,
                        9'h043, 9'h082, 9'h025, 2'(r)));
    end
    // Box extremes: empty and oversized.
    send_ray(pack_ray(0, 0, 0, 30000, 30000, 30000, 9'h000, 9'h000, 9'h000, Rot90));
    send_ray(pack_ray(32768, 32768, 32768, 1, -1, 1, 9'h1ff, 9'h1ff, 9'h1ff, Rot270));
    // Origin extremes saturate the times; direction extremes at the ends of the 18-bit range.
    send_ray(pack_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, -1, -1,
                      full_box, full_box, full_box, RotNone));
    send_ray(pack_ray(32'h80000000, 32'h7fffffff, 32'h80000000, 131071, -131072, 65536,
                      9'h1ff, 9'h000, 9'h1ff, Rot180));
    send_ray(pack_ray(-1, -1, -1, -131072, 131071, -65536, full_box, full_box, full_box,
                      Rot90));
    // Box behind the ray misses.
    send_ray(pack_ray(131072, 32768, 32768, 65536, 0, 0, full_box, full_box, full_box, RotNone));
  endtask

  task automatic test_no_idle();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    random_rays(350);
  endtask

  task automatic test_sender_idle();
    sender_idle_pct = 86;
    receiver_stall_pct = 0;
    random_rays(350);
  endtask

  task automatic test_receiver_stall();
    sender_idle_pct = 0;
    receiver_stall_pct = 86;
    random_rays(350);
  endtask

  task automatic test_both_idle();
    sender_idle_pct = 21;
    receiver_stall_pct = 21;
    random_rays(350);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    s_axis_tvalid <= 1'b0;
    while (hit_face_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && hit_face_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/rbsh_pkg.sv
hdl/rbsh_front.sv
hdl/rbsh_fifo.sv
hdl/rbsh_div.sv
hdl/rbsh_back.sv
hdl/ray_box_slab_hit_face.sv
tb/tb_ray_box_slab_hit_face.sv
